// File: rtl/core/asn_pkg.sv
// Shared types and constants of the audio sample normalizer.
// Used by every module of the block; depends on nothing else.
package asn_pkg;

    localparam int RAW_W      = 32;
    localparam int BLEN_W     = 16;
    localparam int VALUE_W    = 34;
    localparam int INDEX_W    = 16;
    localparam int FILL_W     = 17;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;
    localparam int PROD_W     = 56;
    localparam int SHIFT_W    = 6;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0]         SAMPLE_BYTES_RST = 3'd2;
    localparam logic               FLOAT_FORMAT_RST = 1'b0;
    localparam logic [CFG_W-1:0]   BUFFER_SIZE_RST  = 16'd16384;
    localparam logic [FILL_W-1:0]  FILL_MAX         = 17'h1FFFF;
    localparam logic [VALUE_W-1:0] POS_MAX          = 34'h1_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_MIN          = 34'h2_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_BYTES = 2'd0,
        CFG_FLOAT_FORMAT = 2'd1,
        CFG_BUFFER_SIZE  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_S8    = 2'd0,
        KIND_S16   = 2'd1,
        KIND_INT32 = 2'd2,
        KIND_FLOAT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [2:0]       sample_bytes;
        logic             float_format;
        logic [CFG_W-1:0] buffer_size;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [RAW_W-1:0]   word;
        logic [INDEX_W-1:0] index;
        logic               restarted;
    } entry_t;

endpackage

// File: rtl/core/audio_sample_normalizer_unit.sv
// Top level of the audio sample normalizer: configuration registers, front end, queue, back end.
// Depends on asn_pkg, asn_front, asn_queue and asn_back.
//
// Channel   Direction  Transfer                      Contents
// s_        in         s_tvalid && s_tready          raw sample, batch length, first flag
// m_        out        m_tvalid && m_tready          Q17.16 value, write index, restart flag
// cfg_      in         cfg_wr_en                     sample_bytes, float_format, buffer_size
//
// One sample is taken per cycle while the queue is not full; a result passes through the queue slot
// and the two conversion registers of the back end before it appears.
// Reset is synchronous and active low; it clears the fill count, the queue and all valids.
// When results are not taken, the queue of QUEUE_DEPTH entries and the two back-end
// registers fill up before s_tready falls.
module audio_sample_normalizer_unit #(
    parameter int QUEUE_DEPTH = asn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [asn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asn_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [asn_pkg::S_TDATA_W-1:0]    s_tdata,   // raw_sample[31:0], batch_length[47:32]
    input  logic [0:0]                       s_tuser,   // first_in_batch[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [asn_pkg::M_TDATA_W-1:0]    m_tdata,   // sample_value[33:0], write_index[49:34]
    output logic [0:0]                       m_tuser    // restarted[0]
);

    asn_pkg::cfg_t   cfg_reg;
    asn_pkg::entry_t push_entry;
    asn_pkg::entry_t pop_entry;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_not_empty;

    logic [asn_pkg::VALUE_W-1:0] sample_value;
    logic [asn_pkg::INDEX_W-1:0] write_index;
    logic                        restarted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_bytes <= asn_pkg::SAMPLE_BYTES_RST;
            cfg_reg.float_format <= asn_pkg::FLOAT_FORMAT_RST;
            cfg_reg.buffer_size  <= asn_pkg::BUFFER_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (asn_pkg::cfg_index_t'(cfg_index))
                asn_pkg::CFG_SAMPLE_BYTES: cfg_reg.sample_bytes <= cfg_data[2:0];
                asn_pkg::CFG_FLOAT_FORMAT: cfg_reg.float_format <= cfg_data[0];
                asn_pkg::CFG_BUFFER_SIZE:  cfg_reg.buffer_size  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    asn_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .raw_sample     (s_tdata[31:0]),
        .first_in_batch (s_tuser[0]),
        .batch_length   (s_tdata[47:32]),
        .queue_full     (queue_full),
        .in_ready       (s_tready),
        .push           (push),
        .entry          (push_entry)
    );

    asn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (queue_not_empty)
    );

    asn_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (queue_not_empty),
        .entry        (pop_entry),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .sample_value (sample_value),
        .write_index  (write_index),
        .restarted    (restarted)
    );

    assign m_tdata = {6'd0, write_index, sample_value};
    assign m_tuser = restarted;

endmodule

// File: rtl/core/asn_front.sv
// Front end: takes input transfers, tracks the buffer fill count and classifies samples.
// Depends on asn_pkg.
module asn_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asn_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [asn_pkg::RAW_W-1:0]     raw_sample,
    input  logic                          first_in_batch,
    input  logic [asn_pkg::BLEN_W-1:0]    batch_length,
    input  logic                          queue_full,
    output logic                          in_ready,
    output logic                          push,
    output asn_pkg::entry_t               entry
);

    logic [asn_pkg::FILL_W-1:0] fill_reg;
    logic [asn_pkg::FILL_W-1:0] fill_next;
    logic [asn_pkg::FILL_W:0]   need;
    logic                       restart;
    logic [asn_pkg::FILL_W-1:0] base;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        need      = {1'b0, fill_reg} + {2'b00, batch_length};
        restart   = first_in_batch && (need > {2'b00, cfg.buffer_size});
        base      = restart ? '0 : fill_reg;
        fill_next = (base == asn_pkg::FILL_MAX) ? base : base + 1'b1;

        entry.index     = base[asn_pkg::FILL_W-1] ? '1 : base[asn_pkg::INDEX_W-1:0];
        entry.restarted = restart;
        entry.word      = raw_sample;
        case (cfg.sample_bytes)
            3'd1: begin
                entry.kind = asn_pkg::KIND_S8;
            end
            3'd3: begin
                entry.kind = cfg.float_format ? asn_pkg::KIND_FLOAT : asn_pkg::KIND_INT32;
                entry.word = {raw_sample[23:0], 8'h00};
            end
            3'd4: begin
                entry.kind = cfg.float_format ? asn_pkg::KIND_FLOAT : asn_pkg::KIND_INT32;
            end
            default: begin
                entry.kind = asn_pkg::KIND_S16;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (push) begin
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/asn_queue.sv
// Short queue of classified samples between the front end and the conversion back end.
// Depends on asn_pkg.
module asn_queue #(
    parameter int DEPTH = asn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  asn_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output asn_pkg::entry_t pop_entry,
    output logic            not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    asn_pkg::entry_t  slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/asn_back.sv
// Back end: converts queued samples to signed Q17.16 in two stages with an output register.
// Depends on asn_pkg.
module asn_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  asn_pkg::entry_t               entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [asn_pkg::VALUE_W-1:0]   sample_value,
    output logic [asn_pkg::INDEX_W-1:0]   write_index,
    output logic                          restarted
);

    typedef struct packed {
        asn_pkg::kind_t                kind;
        logic                          neg;
        logic [asn_pkg::VALUE_W-1:0]   direct;
        logic [31:0]                   mag;
        logic [31:0]                   tsum;
        logic [asn_pkg::PROD_W-1:0]    prod;
        logic [asn_pkg::SHIFT_W-1:0]   shamt;
        logic                          zero;
        logic                          sat;
        logic [asn_pkg::INDEX_W-1:0]   index;
        logic                          restarted;
    } stage_t;

    stage_t                      s1_next;
    stage_t                      s1_reg;
    logic                        s1_valid_reg;
    logic                        out_valid_reg;
    logic                        out_adv;
    logic                        s1_adv;
    logic [asn_pkg::VALUE_W-1:0] value_next;
    logic [asn_pkg::VALUE_W-1:0] value_reg;
    logic [asn_pkg::INDEX_W-1:0] index_reg;
    logic                        restarted_reg;

    logic [17:0]                 s8_ext;
    logic [17:0]                 s8_scaled;
    logic [7:0]                  expo;
    logic [22:0]                 frac;
    logic [39:0]                 mant_scaled;
    logic [7:0]                  shamt_full;

    logic [16:0]                 digit_sum;
    logic [1:0]                  round_up;
    logic [32:0]                 int_q;
    logic [33:0]                 int_qx;
    logic [asn_pkg::PROD_W-1:0]  shifted;
    logic [asn_pkg::PROD_W:0]    flt_q;
    logic                        flt_over;

    assign out_adv = !out_valid_reg || out_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = in_valid && s1_adv;

    always_comb begin
        s8_ext      = {{10{entry.word[7]}}, entry.word[7:0]};
        s8_scaled   = (s8_ext <<< 8) - s8_ext;
        expo        = entry.word[30:23];
        frac        = entry.word[22:0];
        mant_scaled = {1'b1, frac, 16'h0000} - {16'h0000, 1'b1, frac};
        shamt_full  = 8'd149 - expo;

        s1_next.kind      = entry.kind;
        s1_next.neg       = entry.word[31];
        s1_next.index     = entry.index;
        s1_next.restarted = entry.restarted;
        s1_next.mag       = entry.word[31] ? (~entry.word + 32'd1) : entry.word;
        s1_next.tsum      = s1_next.mag + 32'd32767;
        s1_next.prod      = {mant_scaled, 16'h0000};
        s1_next.shamt     = shamt_full[asn_pkg::SHIFT_W-1:0];
        s1_next.sat       = (expo == 8'hFF) ? (frac == '0) : (expo >= 8'd150);
        s1_next.zero      = ((expo == 8'hFF) && (frac != '0)) || (expo <= 8'd92);
        if (entry.kind == asn_pkg::KIND_S8) begin
            s1_next.direct = {s8_scaled, 16'h0000};
        end else begin
            s1_next.direct = {{2{entry.word[15]}}, entry.word[15:0], 16'h0000};
        end
    end

    always_comb begin
        digit_sum = {1'b0, s1_reg.tsum[31:16]} + {1'b0, s1_reg.tsum[15:0]};
        if (digit_sum >= 17'd131070) begin
            round_up = 2'd2;
        end else if (digit_sum >= 17'd65535) begin
            round_up = 2'd1;
        end else begin
            round_up = 2'd0;
        end
        int_q  = {1'b0, s1_reg.mag} + {17'd0, s1_reg.tsum[31:16]} + {31'd0, round_up};
        int_qx = {1'b0, int_q};

        shifted  = s1_reg.prod >> s1_reg.shamt;
        flt_q    = ({1'b0, shifted} + 57'd1) >> 1;
        flt_over = s1_reg.neg ? (flt_q > 57'h2_0000_0000) : (flt_q > 57'h1_FFFF_FFFF);

        case (s1_reg.kind)
            asn_pkg::KIND_INT32: begin
                value_next = s1_reg.neg ? (~int_qx + 34'd1) : int_qx;
            end
            asn_pkg::KIND_FLOAT: begin
                if (s1_reg.sat || (!s1_reg.zero && flt_over)) begin
                    value_next = s1_reg.neg ? asn_pkg::NEG_MIN : asn_pkg::POS_MAX;
                end else if (s1_reg.zero) begin
                    value_next = '0;
                end else if (s1_reg.neg) begin
                    value_next = ~flt_q[asn_pkg::VALUE_W-1:0] + 34'd1;
                end else begin
                    value_next = flt_q[asn_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                value_next = s1_reg.direct;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= pop;
            end
            if (out_adv) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_reg <= s1_next;
        end
        if (out_adv && s1_valid_reg) begin
            value_reg     <= value_next;
            index_reg     <= s1_reg.index;
            restarted_reg <= s1_reg.restarted;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = value_reg;
    assign write_index  = index_reg;
    assign restarted    = restarted_reg;

endmodule

// File: rtl/core/asn_checker.sv
// Port-level checks of the audio sample normalizer, bound to its top level.
// Depends on asn_pkg and audio_sample_normalizer_unit.
module asn_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [asn_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result changed before its transfer.");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("Result shown right after reset.");

    a_restart_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[49:34] == '0)
        else $error("Restarted sample does not go to buffer position zero.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:50] == '0)
        else $error("Padding bits of the result are not zero.");

    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> s_tready)
        else $error("Input not ready after reset.");

endmodule

bind audio_sample_normalizer_unit asn_checker u_asn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
